>>> hdl/mfu_pkg.sv
// Package for the motor feedback unwrap block.
// Holds widths, register codes, reset values and the beat and stage types.
// No dependencies.
package mfu_pkg;

  localparam int unsigned ENCODER_COUNTS = 8192;
  localparam int unsigned POS_W          = $clog2(ENCODER_COUNTS);
  localparam int unsigned HALF_TURN      = ENCODER_COUNTS / 2;
  localparam int unsigned STEP_W         = POS_W + 1;
  localparam int unsigned ID_W           = 11;
  localparam int unsigned SCALE_W        = 32;
  localparam int unsigned PROD_W         = STEP_W + SCALE_W + 1;
  localparam int unsigned ACC_W          = 64;
  localparam int unsigned SUM_W          = 48;
  localparam int unsigned SUM_LSB        = 16;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_IDX_W      = 8;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [ID_W-1:0]    MOTOR_ID_RST    = 11'd513;
  localparam logic [SCALE_W-1:0] COUNT_SCALE_RST = 32'd188743680;
  localparam logic [BYTE_W-1:0]  TEMP_LIMIT_RST  = 8'd80;
  localparam logic [BYTE_W-1:0]  COUNT_LIMIT_RST = 8'd200;
  localparam logic [BYTE_W-1:0]  HOT_COUNT_MAX   = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOTOR_ID    = 8'd0,
    REG_COUNT_SCALE = 8'd1,
    REG_TEMP_LIMIT  = 8'd2,
    REG_COUNT_LIMIT = 8'd3
  } mfu_reg_e;

  typedef struct packed {
    logic [ID_W-1:0]    motor_id;
    logic [SCALE_W-1:0] count_scale;
    logic [BYTE_W-1:0]  temp_limit;
    logic [BYTE_W-1:0]  count_limit;
  } mfu_cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]   can_id;
    logic [BYTE_W-1:0] position_high;
    logic [BYTE_W-1:0] position_low;
    logic [BYTE_W-1:0] speed_high;
    logic [BYTE_W-1:0] speed_low;
    logic [BYTE_W-1:0] current_high;
    logic [BYTE_W-1:0] current_low;
    logic [BYTE_W-1:0] temperature_byte;
  } mfu_in_t;

  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic signed [15:0]      speed;
    logic signed [15:0]      drive_current;
    logic [BYTE_W-1:0]       temperature;
    logic signed [SUM_W-1:0] angle_sum;
    logic                    over_temperature;
  } mfu_out_t;

  typedef struct packed {
    logic [POS_W-1:0]         position;
    logic signed [15:0]       speed;
    logic signed [15:0]       drive_current;
    logic [BYTE_W-1:0]        temperature;
    logic                     over_temperature;
    logic                     seed;
    logic signed [STEP_W-1:0] step;
  } mfu_s1_t;

  typedef struct packed {
    logic [POS_W-1:0]         position;
    logic signed [15:0]       speed;
    logic signed [15:0]       drive_current;
    logic [BYTE_W-1:0]        temperature;
    logic                     over_temperature;
    logic                     seed;
    logic signed [PROD_W-1:0] product;
  } mfu_s2_t;

endpackage

>>> hdl/mfu_cfg.sv
// Configuration register file of the motor feedback unwrap block.
// Depends on mfu_pkg for register codes, reset values and the config struct.
module mfu_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mfu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mfu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output mfu_pkg::mfu_cfg_t                cfg_o
);

  mfu_pkg::mfu_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (mfu_pkg::mfu_reg_e'(cfg_index_i))
        mfu_pkg::REG_MOTOR_ID:    cfg_d.motor_id    = cfg_data_i[mfu_pkg::ID_W-1:0];
        mfu_pkg::REG_COUNT_SCALE: cfg_d.count_scale = cfg_data_i[mfu_pkg::SCALE_W-1:0];
        mfu_pkg::REG_TEMP_LIMIT:  cfg_d.temp_limit  = cfg_data_i[mfu_pkg::BYTE_W-1:0];
        mfu_pkg::REG_COUNT_LIMIT: cfg_d.count_limit = cfg_data_i[mfu_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motor_id    <= mfu_pkg::MOTOR_ID_RST;
      cfg_q.count_scale <= mfu_pkg::COUNT_SCALE_RST;
      cfg_q.temp_limit  <= mfu_pkg::TEMP_LIMIT_RST;
      cfg_q.count_limit <= mfu_pkg::COUNT_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hdl/mfu_decode.sv
// Input stage: identifier match, payload unpack, shortest-way unwrap, temperature run.
// Holds the seed flag, previous position, hot count and sticky flag.
// Depends on mfu_pkg.
module mfu_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfu_pkg::mfu_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mfu_pkg::mfu_in_t  in_beat_i,
  output logic              s1_valid_o,
  input  logic              s1_ready_i,
  output mfu_pkg::mfu_s1_t  s1_o
);

  localparam logic signed [mfu_pkg::STEP_W-1:0] Half =
    mfu_pkg::STEP_W'(mfu_pkg::HALF_TURN);
  localparam logic signed [mfu_pkg::STEP_W-1:0] Turn =
    mfu_pkg::STEP_W'(mfu_pkg::ENCODER_COUNTS);

  logic                            valid_q, valid_d;
  mfu_pkg::mfu_s1_t                beat_q, beat_d;
  logic                            seeded_q, seeded_d;
  logic [mfu_pkg::POS_W-1:0]       prev_q, prev_d;
  logic [mfu_pkg::BYTE_W-1:0]      hot_q, hot_d;
  logic                            flag_q, flag_d;

  logic                            take;
  logic [mfu_pkg::POS_W-1:0]       pos;
  logic [mfu_pkg::POS_W-1:0]       prev_eff;
  logic signed [mfu_pkg::STEP_W-1:0] diff;
  logic signed [mfu_pkg::STEP_W-1:0] wrap;
  logic signed [mfu_pkg::STEP_W-1:0] step;
  logic [mfu_pkg::BYTE_W-1:0]      hot_inc;

  assign in_ready_o = !valid_q || s1_ready_i;
  assign take       = in_valid_i && in_ready_o && (in_beat_i.can_id == cfg_i.motor_id);
  assign s1_valid_o = valid_q;
  assign s1_o       = beat_q;

  always_comb begin
    pos      = mfu_pkg::POS_W'({in_beat_i.position_high, in_beat_i.position_low});
    prev_eff = seeded_q ? prev_q : pos;
    diff     = $signed({1'b0, pos}) - $signed({1'b0, prev_eff});
    // one step-width wrap: adding or subtracting a turn gives the same bits
    wrap     = diff - Turn;
    step     = ((diff < Half) && (diff > -Half)) ? diff : wrap;
    hot_inc  = (hot_q == mfu_pkg::HOT_COUNT_MAX) ? hot_q : hot_q + 1'b1;

    seeded_d = seeded_q;
    prev_d   = prev_q;
    hot_d    = hot_q;
    flag_d   = flag_q;
    if (take) begin
      seeded_d = 1'b1;
      prev_d   = pos;
      if (in_beat_i.temperature_byte > cfg_i.temp_limit) begin
        if (hot_inc > cfg_i.count_limit) begin
          flag_d = 1'b1;
          hot_d  = '0;
        end else begin
          hot_d = hot_inc;
        end
      end else begin
        hot_d = '0;
      end
    end

    valid_d = in_ready_o ? take : valid_q;
    beat_d  = beat_q;
    if (take) begin
      beat_d.position         = pos;
      beat_d.speed            = $signed({in_beat_i.speed_high, in_beat_i.speed_low});
      beat_d.drive_current    = $signed({in_beat_i.current_high, in_beat_i.current_low});
      beat_d.temperature      = in_beat_i.temperature_byte;
      beat_d.over_temperature = flag_d;
      beat_d.seed             = !seeded_q;
      beat_d.step             = step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      seeded_q <= 1'b0;
      prev_q   <= '0;
      hot_q    <= '0;
      flag_q   <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      seeded_q <= seeded_d;
      prev_q   <= prev_d;
      hot_q    <= hot_d;
      flag_q   <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

endmodule

>>> hdl/mfu_scale.sv
// Scale stage: signed position step times the unsigned degrees-per-count factor.
// Depends on mfu_pkg.
module mfu_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfu_pkg::mfu_cfg_t cfg_i,
  input  logic              s1_valid_i,
  output logic              s1_ready_o,
  input  mfu_pkg::mfu_s1_t  s1_i,
  output logic              s2_valid_o,
  input  logic              s2_ready_i,
  output mfu_pkg::mfu_s2_t  s2_o
);

  logic             valid_q;
  mfu_pkg::mfu_s2_t beat_q, beat_d;
  logic             load;
  logic signed [mfu_pkg::PROD_W-1:0] step_ext;
  logic signed [mfu_pkg::PROD_W-1:0] scale_ext;

  assign s1_ready_o = !valid_q || s2_ready_i;
  assign load       = s1_valid_i && s1_ready_o;
  assign s2_valid_o = valid_q;
  assign s2_o       = beat_q;

  always_comb begin
    step_ext  = $signed({{(mfu_pkg::PROD_W - mfu_pkg::STEP_W){s1_i.step[mfu_pkg::STEP_W-1]}},
                         s1_i.step});
    scale_ext = $signed({{(mfu_pkg::PROD_W - mfu_pkg::SCALE_W){1'b0}}, cfg_i.count_scale});
    beat_d                  = beat_q;
    if (load) begin
      beat_d.position         = s1_i.position;
      beat_d.speed            = s1_i.speed;
      beat_d.drive_current    = s1_i.drive_current;
      beat_d.temperature      = s1_i.temperature;
      beat_d.over_temperature = s1_i.over_temperature;
      beat_d.seed             = s1_i.seed;
      beat_d.product          = step_ext * scale_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

endmodule

>>> hdl/mfu_accum.sv
// Accumulate stage and result register: multi-turn angle sum and the result beat.
// Depends on mfu_pkg.
module mfu_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s2_valid_i,
  output logic              s2_ready_o,
  input  mfu_pkg::mfu_s2_t  s2_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mfu_pkg::mfu_out_t out_beat_o
);

  logic                             valid_q;
  mfu_pkg::mfu_out_t                beat_q, beat_d;
  logic [mfu_pkg::ACC_W-1:0]        acc_q, acc_d;
  logic [mfu_pkg::ACC_W-1:0]        prod_ext;
  logic                             load;

  assign s2_ready_o  = !valid_q || out_ready_i;
  assign load        = s2_valid_i && s2_ready_o;
  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

  always_comb begin
    prod_ext = {{(mfu_pkg::ACC_W - mfu_pkg::PROD_W){s2_i.product[mfu_pkg::PROD_W-1]}},
                s2_i.product};
    acc_d  = acc_q;
    beat_d = beat_q;
    if (load) begin
      acc_d = (s2_i.seed ? '0 : acc_q) + prod_ext;
      beat_d.position         = s2_i.position;
      beat_d.speed            = s2_i.speed;
      beat_d.drive_current    = s2_i.drive_current;
      beat_d.temperature      = s2_i.temperature;
      beat_d.angle_sum        =
        $signed(acc_d[mfu_pkg::SUM_LSB +: mfu_pkg::SUM_W]);
      beat_d.over_temperature = s2_i.over_temperature;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      acc_q <= acc_d;
      if (s2_ready_o) begin
        valid_q <= s2_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

endmodule

>>> hdl/motor_feedback_unwrap.sv
// Motor feedback unwrap: frame decode, multi-turn angle and over-temperature flag.
// Each accepted matching frame moves through the decode, scale and result registers in turn.
// Throughput: one frame per cycle while out_ready_i is high; each of the three stage
// registers has its own valid and takes a new beat whenever it is empty or its beat moves on.
// Frames with another identifier are taken and dropped. Reset clears all stage valids,
// the angle and temperature state, and loads the register reset values.
module motor_feedback_unwrap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mfu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mfu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mfu_pkg::mfu_in_t               in_beat_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mfu_pkg::mfu_out_t              out_beat_o
);

  mfu_pkg::mfu_cfg_t cfg;
  logic              s1_valid, s1_ready;
  mfu_pkg::mfu_s1_t  s1;
  logic              s2_valid, s2_ready;
  mfu_pkg::mfu_s2_t  s2;

  mfu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mfu_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_o       (s1)
  );

  mfu_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_i       (s1),
    .s2_valid_o (s2_valid),
    .s2_ready_i (s2_ready),
    .s2_o       (s2)
  );

  mfu_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_valid_i  (s2_valid),
    .s2_ready_o  (s2_ready),
    .s2_i        (s2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
